// File: rtl/mrmp_pkg.sv
`timescale 1ns / 1ps

package mrmp_pkg;

   // Longest run of used pixels counted in one row; later used pixels are dropped.
   localparam int MAX_ROW_PIXELS = 8192;

   localparam int NUM_CHANNELS = 5;
   localparam int CHAN_W       = 8;
   localparam int MASK_W       = 8;
   localparam int FRAC_W       = 8;
   localparam int MEAN_W       = 16;

   localparam int COUNT_W  = $clog2(MAX_ROW_PIXELS + 1);
   localparam int TOTAL_W  = $clog2(MAX_ROW_PIXELS * NUM_CHANNELS * 255 + 1);
   localparam int DEN_W    = $clog2(MAX_ROW_PIXELS * NUM_CHANNELS + 1);
   localparam int REM_W    = DEN_W + 1;
   localparam int ALU_W    = TOTAL_W + 1;
   localparam int STEP_W   = $clog2(MEAN_W);
   localparam int CH_IDX_W = $clog2(NUM_CHANNELS);

   localparam int REQ_DATA_W = MASK_W + NUM_CHANNELS * CHAN_W;

   localparam logic [MEAN_W-1:0] EMPTY_MEAN = MEAN_W'(128 << FRAC_W);

   typedef enum logic [5:0] {
      ST_IDLE   = 6'b000001,
      ST_ADD    = 6'b000010,
      ST_CNT    = 6'b000100,
      ST_DEN    = 6'b001000,
      ST_DIV    = 6'b010000,
      ST_FINISH = 6'b100000
   } state_type;

   typedef struct packed {
      logic [ALU_W-1:0] op_a;
      logic [ALU_W-1:0] op_b;
      logic             sub;
   } alu_req_type;

endpackage

// File: rtl/mrmp_addsub.sv
`timescale 1ns / 1ps

// Shared add/subtract unit. On subtract the top bit is the borrow.
module mrmp_addsub (
   input  mrmp_pkg::alu_req_type         alu_req,
   output logic [mrmp_pkg::ALU_W-1:0]    alu_result
);

   always_comb begin
      if (alu_req.sub) begin
         alu_result = alu_req.op_a - alu_req.op_b;
      end else begin
         alu_result = alu_req.op_a + alu_req.op_b;
      end
   end

endmodule

// File: rtl/masked_row_mean_profile.sv
`timescale 1ns / 1ps

// Masked row mean: pixels arrive one beat each in raster order, tlast marking the
// last pixel of a row. A pixel with a nonzero mask byte adds its five channel
// samples to the row total and bumps the used count (up to MAX_ROW_PIXELS per
// row, later used pixels are ignored). The last pixel of a row produces one
// result beat: row mean total / (5 * count) as unsigned 8.8, truncated, with
// tuser low; a row with no used pixel gives 128.0 (0x8000) with tuser high.
// All arithmetic goes through a single add/subtract unit under a small state
// machine, and req_tready is high only while that machine is idle.
// A masked pixel leaves the machine idle, so the next pixel can be taken in the
// next cycle; a used pixel takes five channel adds plus a count increment.
// A row-end pixel then goes on to the divisor (5 * count), 16 restoring-divide
// steps and loading of the result register; a masked row-end pixel skips the
// adds and the increment, and an empty row skips the divide steps. A result
// beat waits in its own register and only a following row end stalls on it.
module masked_row_mean_profile (
   input  logic                              clock,
   input  logic                              reset,

   input  logic                              req_tvalid,
   output logic                              req_tready,
   // [7:0] mask_value, [15:8] channel_red, [23:16] channel_green,
   // [31:24] channel_blue, [39:32] channel_infrared, [47:40] channel_nadir
   input  logic [mrmp_pkg::REQ_DATA_W-1:0]   req_tdata,
   input  logic                              req_tlast,    // row_end

   output logic                              rsp_tvalid,
   input  logic                              rsp_tready,
   // [15:0] row_mean
   output logic [mrmp_pkg::MEAN_W-1:0]       rsp_tdata,
   // [0] row_empty
   output logic                              rsp_tuser
);

   mrmp_pkg::state_type state_ff, state_in;

   logic [mrmp_pkg::TOTAL_W-1:0]  row_total_ff, row_total_in;
   logic [mrmp_pkg::COUNT_W-1:0]  used_count_ff, used_count_in;
   logic [mrmp_pkg::STEP_W-1:0]   step_ff, step_in;
   logic [mrmp_pkg::CHAN_W-1:0]   chan_ff [mrmp_pkg::NUM_CHANNELS];
   logic                          last_ff, last_in;
   logic [mrmp_pkg::DEN_W-1:0]    den_ff, den_in;
   logic [mrmp_pkg::REM_W-1:0]    rem_ff, rem_in;
   logic [mrmp_pkg::MEAN_W-1:0]   quot_ff, quot_in;   // numerator bits out, quotient bits in
   logic                          empty_ff, empty_in;

   logic                          rsp_valid_ff, rsp_valid_in;
   logic [mrmp_pkg::MEAN_W-1:0]   rsp_mean_ff, rsp_mean_in;
   logic                          rsp_empty_ff, rsp_empty_in;

   mrmp_pkg::alu_req_type         alu_req;
   logic [mrmp_pkg::ALU_W-1:0]    alu_result;
   logic [mrmp_pkg::CHAN_W-1:0]   chan_sel;
   logic [mrmp_pkg::REM_W-1:0]    trial;
   logic                          borrow;
   logic                          req_beat;
   logic                          pix_used;
   logic                          out_free;

   assign req_tready = (state_ff == mrmp_pkg::ST_IDLE);
   assign req_beat   = req_tvalid && req_tready;
   assign pix_used   = (req_tdata[mrmp_pkg::MASK_W-1:0] != '0) &&
                       (used_count_ff < mrmp_pkg::COUNT_W'(mrmp_pkg::MAX_ROW_PIXELS));
   assign out_free   = !rsp_valid_ff || rsp_tready;

   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = rsp_mean_ff;
   assign rsp_tuser  = rsp_empty_ff;

   always_comb begin
      if (step_ff[mrmp_pkg::CH_IDX_W-1:0] < mrmp_pkg::CH_IDX_W'(mrmp_pkg::NUM_CHANNELS)) begin
         chan_sel = chan_ff[step_ff[mrmp_pkg::CH_IDX_W-1:0]];
      end else begin
         chan_sel = '0;
      end
   end

   // restoring divide: shift next numerator bit into the partial remainder
   assign trial  = {rem_ff[mrmp_pkg::DEN_W-1:0], quot_ff[mrmp_pkg::MEAN_W-1]};
   assign borrow = alu_result[mrmp_pkg::ALU_W-1];

   // operand steering for the shared unit
   always_comb begin
      alu_req = '0;
      unique case (state_ff) inside
         mrmp_pkg::ST_ADD: begin
            alu_req.op_a = mrmp_pkg::ALU_W'(row_total_ff);
            alu_req.op_b = mrmp_pkg::ALU_W'(chan_sel);
         end
         mrmp_pkg::ST_CNT: begin
            alu_req.op_a = mrmp_pkg::ALU_W'(used_count_ff);
            alu_req.op_b = mrmp_pkg::ALU_W'(1);
         end
         mrmp_pkg::ST_DEN: begin
            // 5 * count = 4 * count + count
            alu_req.op_a = mrmp_pkg::ALU_W'({used_count_ff, 2'b00});
            alu_req.op_b = mrmp_pkg::ALU_W'(used_count_ff);
         end
         mrmp_pkg::ST_DIV: begin
            alu_req.op_a = mrmp_pkg::ALU_W'(trial);
            alu_req.op_b = mrmp_pkg::ALU_W'(den_ff);
            alu_req.sub  = 1'b1;
         end
         mrmp_pkg::ST_IDLE, mrmp_pkg::ST_FINISH: begin
            alu_req = '0;
         end
         default: begin
            alu_req = '0;
         end
      endcase
   end

   mrmp_addsub u_addsub (
      .alu_req    (alu_req),
      .alu_result (alu_result)
   );

   always_comb begin
      state_in      = state_ff;
      row_total_in  = row_total_ff;
      used_count_in = used_count_ff;
      step_in       = step_ff;
      last_in       = last_ff;
      den_in        = den_ff;
      rem_in        = rem_ff;
      quot_in       = quot_ff;
      empty_in      = empty_ff;
      rsp_valid_in  = rsp_valid_ff && !rsp_tready;
      rsp_mean_in   = rsp_mean_ff;
      rsp_empty_in  = rsp_empty_ff;

      unique case (state_ff)
         mrmp_pkg::ST_IDLE: begin
            if (req_beat) begin
               last_in = req_tlast;
               step_in = '0;
               if (pix_used) begin
                  state_in = mrmp_pkg::ST_ADD;
               end else if (req_tlast) begin
                  state_in = mrmp_pkg::ST_DEN;
               end
            end
         end
         mrmp_pkg::ST_ADD: begin
            row_total_in = alu_result[mrmp_pkg::TOTAL_W-1:0];
            if (step_ff == mrmp_pkg::STEP_W'(mrmp_pkg::NUM_CHANNELS - 1)) begin
               step_in  = '0;
               state_in = mrmp_pkg::ST_CNT;
            end else begin
               step_in = step_ff + 1'b1;
            end
         end
         mrmp_pkg::ST_CNT: begin
            used_count_in = alu_result[mrmp_pkg::COUNT_W-1:0];
            state_in      = last_ff ? mrmp_pkg::ST_DEN : mrmp_pkg::ST_IDLE;
         end
         mrmp_pkg::ST_DEN: begin
            den_in  = alu_result[mrmp_pkg::DEN_W-1:0];
            // numerator = total << 8; upper half seeds the remainder
            rem_in  = mrmp_pkg::REM_W'(row_total_ff >> (mrmp_pkg::MEAN_W - mrmp_pkg::FRAC_W));
            quot_in = mrmp_pkg::MEAN_W'({row_total_ff, mrmp_pkg::FRAC_W'(0)});
            step_in = '0;
            if (used_count_ff == '0) begin
               empty_in = 1'b1;
               state_in = mrmp_pkg::ST_FINISH;
            end else begin
               empty_in = 1'b0;
               state_in = mrmp_pkg::ST_DIV;
            end
         end
         mrmp_pkg::ST_DIV: begin
            rem_in  = borrow ? trial : alu_result[mrmp_pkg::REM_W-1:0];
            quot_in = {quot_ff[mrmp_pkg::MEAN_W-2:0], !borrow};
            step_in = step_ff + 1'b1;
            if (step_ff == mrmp_pkg::STEP_W'(mrmp_pkg::MEAN_W - 1)) begin
               state_in = mrmp_pkg::ST_FINISH;
            end
         end
         mrmp_pkg::ST_FINISH: begin
            if (out_free) begin
               rsp_valid_in  = 1'b1;
               rsp_mean_in   = empty_ff ? mrmp_pkg::EMPTY_MEAN : quot_ff;
               rsp_empty_in  = empty_ff;
               row_total_in  = '0;
               used_count_in = '0;
               state_in      = mrmp_pkg::ST_IDLE;
            end
         end
         default: begin
            state_in = mrmp_pkg::ST_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff      <= mrmp_pkg::ST_IDLE;
         row_total_ff  <= '0;
         used_count_ff <= '0;
         step_ff       <= '0;
         rsp_valid_ff  <= 1'b0;
      end else begin
         state_ff      <= state_in;
         row_total_ff  <= row_total_in;
         used_count_ff <= used_count_in;
         step_ff       <= step_in;
         rsp_valid_ff  <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      last_ff      <= last_in;
      den_ff       <= den_in;
      rem_ff       <= rem_in;
      quot_ff      <= quot_in;
      empty_ff     <= empty_in;
      rsp_mean_ff  <= rsp_mean_in;
      rsp_empty_ff <= rsp_empty_in;
      if (req_beat) begin
         for (int i = 0; i < mrmp_pkg::NUM_CHANNELS; i++) begin
            chan_ff[i] <= req_tdata[mrmp_pkg::MASK_W + i * mrmp_pkg::CHAN_W +: mrmp_pkg::CHAN_W];
         end
      end
   end

   // a new result only comes out of the finish step
   a_rsp_from_finish: assert property (@(posedge clock) disable iff (reset)
      $rose(rsp_valid_ff) |-> $past(state_ff == mrmp_pkg::ST_FINISH))
      else $error("result beat raised outside finish step");

   a_count_limit: assert property (@(posedge clock) disable iff (reset)
      used_count_ff <= mrmp_pkg::COUNT_W'(mrmp_pkg::MAX_ROW_PIXELS))
      else $error("used count beyond row limit");

   a_rem_below_den: assert property (@(posedge clock) disable iff (reset)
      (state_ff == mrmp_pkg::ST_DIV) |-> (rem_ff < mrmp_pkg::REM_W'(den_ff)))
      else $error("partial remainder not below divisor");

   a_empty_mean: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid_ff && rsp_empty_ff) |-> (rsp_mean_ff == mrmp_pkg::EMPTY_MEAN))
      else $error("empty row without 128.0 mean");

endmodule
